[src/linear_probe_hash_table_defines.svh]
// assertion macros used by the hash table controller
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lpht_pkg.sv]
// types, constants and hash functions of the linear probe hash table
package lpht_pkg;

    // table geometry, slot count is a power of two so the index wraps by itself
    localparam int SLOT_W     = 10;
    localparam int SLOTS      = 1 << SLOT_W;
    localparam int KEY_BYTES  = 8;

    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int VAL_W      = 64;
    localparam int SLOT_OUT_W = 10;
    localparam int ACT_W      = 2;
    localparam int STS_W      = 2;
    localparam int ENTRY_W    = VAL_W + LEN_W + KEY_W;

    // hash shape
    localparam int HASH_W     = 32;
    localparam int HASH_SHL   = 4;
    localparam int HASH_SHR   = 28;
    localparam int FOLD_A     = 10;
    localparam int FOLD_B     = 20;

    // stream packing
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 80;

    // actions
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_DUP      = 2'd1;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd2;
    localparam logic [STS_W-1:0] STS_FULL     = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic clr_en;
        logic load_req;
        logic load_home;
        logic probe_next;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic hit;
        logic empty;
        logic exhausted;
        logic out_free;
    } t_sts;

    // clamp the key length to the supported byte count
    function automatic logic [LEN_W-1:0] f_clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = (len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len;
        return r;
    endfunction

    // zero the bytes at and above the key length
    function automatic logic [KEY_W-1:0] f_mask_key(input logic [KEY_W-1:0] key,
                                                     input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] r;
        r = key;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (LEN_W'(b) >= len) begin
                r[8*b +: 8] = 8'd0;
            end
        end
        return r;
    endfunction

    // rotate hash over the in-use bytes, folded and cut down to a slot index
    function automatic logic [SLOT_W-1:0] f_home_slot(input logic [KEY_W-1:0] key,
                                                       input logic [LEN_W-1:0] len);
        logic [HASH_W-1:0] h;
        h = HASH_W'(len);
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (LEN_W'(i) < len) begin
                h = (h << HASH_SHL) ^ (h >> HASH_SHR) ^ HASH_W'(key[8*i +: 8]);
            end
        end
        h = h ^ (h >> FOLD_A) ^ (h >> FOLD_B);
        return h[SLOT_W-1:0];
    endfunction

endpackage

[src/lpht_ram.sv]
// generic single port ram with registered read
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/lpht_dp.sv]
// datapath of the hash table: request registers, probe index, stores, result register
module lpht_dp
    import lpht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [IN_DATA_W-1:0]  i_req_data,
    input  logic [ACT_W-1:0]      i_req_action,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [OUT_DATA_W-1:0] o_res_data,
    output logic [STS_W-1:0]      o_res_status
);

    logic [ACT_W-1:0]      r_action;
    logic [KEY_W-1:0]      r_key;
    logic [LEN_W-1:0]      r_len;
    logic [VAL_W-1:0]      r_val;
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]     r_cnt;
    logic [SLOT_W-1:0]     r_clr;
    logic                  r_out_valid;
    logic [STS_W-1:0]      r_out_status;
    logic [VAL_W-1:0]      r_out_value;
    logic [SLOT_OUT_W-1:0] r_out_slot;

    logic [LEN_W-1:0]      n_len;
    logic [STS_W-1:0]      n_status;
    logic [VAL_W-1:0]      n_value;
    logic [SLOT_OUT_W-1:0] n_slot;

    logic                  vld_rd;
    logic [ENTRY_W-1:0]    ent_rd;
    logic                  vld_we;
    logic                  vld_wdata;
    logic [SLOT_W-1:0]     vld_addr;
    logic                  ent_we;
    logic                  is_write;
    logic                  is_update;
    logic                  hit;
    logic                  empty;

    assign n_len     = f_clamp_len(i_req_data[KEY_W +: LEN_W]);
    assign is_write  = (r_action == ACT_INSERT) || (r_action == ACT_UPDATE);
    assign is_update = (r_action == ACT_UPDATE);

    assign empty = !vld_rd;
    assign hit   = vld_rd && (ent_rd[KEY_W +: LEN_W] == r_len) && (ent_rd[KEY_W-1:0] == r_key);

    // valid bits are swept to zero after reset, then written on each new entry
    assign vld_we    = i_cmd.clr_en || (i_cmd.finish && empty && is_write);
    assign vld_wdata = !i_cmd.clr_en;
    assign vld_addr  = i_cmd.clr_en ? r_clr : r_idx;
    assign ent_we    = i_cmd.finish && is_write && (empty || (hit && is_update));

    lpht_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_addr  (vld_addr),
        .i_wdata (vld_wdata),
        .o_rdata (vld_rd)
    );

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_addr  (r_idx),
        .i_wdata ({r_val, r_len, r_key}),
        .o_rdata (ent_rd)
    );

    // result of the probe that just ended
    always_comb begin
        n_status = STS_OK;
        n_value  = '0;
        n_slot   = '0;
        if (empty) begin
            if (is_write) begin
                n_slot = SLOT_OUT_W'(r_idx);
            end else begin
                n_status = STS_NOTFOUND;
            end
        end else if (hit) begin
            n_slot = SLOT_OUT_W'(r_idx);
            if (r_action == ACT_INSERT) begin
                n_status = STS_DUP;
            end else if (!is_write) begin
                n_value = ent_rd[KEY_W + LEN_W +: VAL_W];
            end
        end else begin
            n_status = is_write ? STS_FULL : STS_NOTFOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_action <= i_req_action;
            r_len    <= n_len;
            r_key    <= f_mask_key(i_req_data[KEY_W-1:0], n_len);
            r_val    <= i_req_data[KEY_W + LEN_W +: VAL_W];
        end
        if (i_cmd.load_home) begin
            r_idx <= f_home_slot(r_key, r_len);
            r_cnt <= '0;
        end else if (i_cmd.probe_next) begin
            r_idx <= r_idx + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
            r_out_slot   <= n_slot;
        end
    end

    assign o_sts.clr_done  = &r_clr;
    assign o_sts.hit       = hit;
    assign o_sts.empty     = empty;
    assign o_sts.exhausted = &r_cnt;
    assign o_sts.out_free  = !r_out_valid || i_res_ready;

    assign o_res_valid  = r_out_valid;
    assign o_res_status = r_out_status;
    assign o_res_data   = {{(OUT_DATA_W - SLOT_OUT_W - VAL_W){1'b0}}, r_out_slot, r_out_value};

endmodule

[src/lpht_ctrl.sv]
// controller of the hash table: clear sweep, hash, probe loop and result hand-off
`include "linear_probe_hash_table_defines.svh"

module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   done;

    assign done = i_sts.empty || i_sts.hit || i_sts.exhausted;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.load_home = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!done) begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_READ;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    `LPHT_ASSERT_IMP(a_finish_free, o_cmd.finish, i_sts.out_free && done, "finish while result busy")
    `LPHT_ASSERT_IMP(a_step_open, o_cmd.probe_next, !i_sts.hit && !i_sts.empty, "probe past end")
    `LPHT_ASSERT_NXT(a_accept_hash, o_cmd.load_req, r_state == S_HASH, "accept without hash")
    `LPHT_ASSERT_IMP(a_clear_quiet, o_cmd.clr_en, !o_cmd.finish && !o_req_ready, "work in clear")

endmodule

[src/linear_probe_hash_table.sv]
// top level of the linear probe hash table
// usage:
//   slave stream carries one request per transaction: tuser is the action
//   (insert if absent, update or insert, find), tdata the key bytes, key
//   length and value to store
//   master stream carries one result per request: tuser is the status
//   (ok, duplicate, not found, table full), tdata the found value and slot
// probe sequence:
//   one request at a time; accept, hash, then for each probed slot a read
//   state (address, registered read) and a check state (compare) on the
//   single port stores; a request can end on its home slot, or probe up
//   to all 1024 slots on a full table
// reset:
//   after reset the valid bits are swept to zero, one slot per cycle, over
//   all 1024 slots; s_axis_tready stays low during the sweep
// stall:
//   the result sits in an output register; a request finishing while it
//   has not been taken waits before writing the store, so nothing is lost
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // key_bytes[63:0], key_len[67:64], value_in[131:68]
    input  logic [ACT_W-1:0]      i_s_axis_tuser,   // action[1:0]
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // value_out[63:0], slot[73:64]
    output logic [STS_W-1:0]      o_m_axis_tuser    // status[1:0]
);

    t_cmd cmd;   // controller commands
    t_sts sts;   // probe and output status

    // sequencer: clear sweep, request capture, probe loop
    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stores, hash, compare and result register
    lpht_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_data   (i_s_axis_tdata),
        .i_req_action (i_s_axis_tuser),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res_data   (o_m_axis_tdata),
        .o_res_status (o_m_axis_tuser)
    );

endmodule
